### hw/rtl/shts_pkg.sv
package shts_pkg;

  // Default number of table entries held in the on-chip memory.
  localparam longint unsigned TableDepthDefault = 64'd65536;

  localparam int unsigned CfgW   = 17;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned CntW   = 32;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned LimitW = 33;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [HalfW-1:0] key_high;
    logic [HalfW-1:0] key_low;
    logic [IdxW-1:0]  entry_index;
    logic [CntW-1:0]  entry_count;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] match_index;
    logic [CntW-1:0] hit_count;
  } out_item_t;

  typedef struct packed {
    logic [HalfW-1:0] key_high;
    logic [HalfW-1:0] key_low;
    logic [CntW-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

### hw/rtl/sorted_hash_table_search.sv
// Sorted key table with binary-search lookup.
//
// Channels: the input channel (in_valid_i, in_stall_o, in_data_i) carries load and
// lookup transactions. A load writes one 128-bit key and its 32-bit count into the
// table and produces no result. A lookup searches the first table_entries entries
// and produces one result transaction on the output channel (out_valid_o,
// out_stall_i, out_data_o). The configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_data_i) writes table_entries and is always ready; the user is to see that it is
// written only while the block is idle, which the block itself does not enforce.
//
// Sequence: a load is written to the table in the accepting cycle. A lookup runs S
// halving steps, about ceil(log2(table_entries)) - 1, so 15 for a full 65536-entry
// table, then tests the range start for equality and, if it does not match, the
// range end; the result is then registered and the next transaction can be accepted.
// Each step has two states, pivot address then compare, since the single table
// read port has a registered output; one 128-bit comparator serves all steps and
// both tests. The input stalls during a lookup. A finished result waits in the output
// register while the next transaction is accepted; if the receiver still stalls when
// another lookup finishes, the search holds until the register frees. Reset clears
// control state and sets table_entries to 1; the table itself is not cleared.
module sorted_hash_table_search #(
  parameter longint unsigned TABLE_DEPTH = shts_pkg::TableDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  shts_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output shts_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [shts_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 64'd1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ExtW  = (AddrW > shts_pkg::IdxW) ? AddrW : shts_pkg::IdxW;
  localparam logic [shts_pkg::LimitW-1:0] DepthLim = shts_pkg::LimitW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CMP,
    S_EQLO,
    S_EQHI,
    S_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [shts_pkg::CfgW-1:0]     entries_q, entries_d;
  logic [AddrW-1:0]              lo_q, lo_d;
  logic [AddrW-1:0]              hi_q, hi_d;
  logic [AddrW-1:0]              piv_q, piv_d;
  logic [shts_pkg::HalfW-1:0]    key_high_q, key_high_d;
  logic [shts_pkg::HalfW-1:0]    key_low_q, key_low_d;
  shts_pkg::out_item_t           res_q, res_d;
  shts_pkg::out_item_t           out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic                          in_accept;
  logic                          out_free;
  logic                          wr_en;
  logic [AddrW-1:0]              wr_addr;
  logic [ExtW-1:0]               wr_idx_ext;
  shts_pkg::entry_t              wr_data;
  logic [AddrW-1:0]              rd_addr;
  shts_pkg::entry_t              rd_data;
  shts_pkg::cmp_res_t            cmp_res;
  logic [shts_pkg::LimitW-1:0]   entries_ext;
  logic [shts_pkg::LimitW-1:0]   n_eff;
  logic [AddrW-1:0]              span;
  logic [ExtW-1:0]               lo_ext;
  logic [ExtW-1:0]               hi_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Loads go straight into the table in the accepting cycle; indexes beyond
  // the table depth are dropped.
  assign wr_idx_ext = ExtW'(in_data_i.entry_index);
  assign wr_addr    = wr_idx_ext[AddrW-1:0];
  assign wr_en      = in_accept && (in_data_i.req_type == shts_pkg::ReqLoad) &&
                      (shts_pkg::LimitW'(in_data_i.entry_index) < DepthLim);
  assign wr_data    = '{key_high: in_data_i.key_high,
                        key_low:  in_data_i.key_low,
                        count:    in_data_i.entry_count};

  // Effective entry count, clamped to the range 1 .. TABLE_DEPTH.
  assign entries_ext = shts_pkg::LimitW'(entries_q);
  always_comb begin
    if (entries_ext == '0) begin
      n_eff = shts_pkg::LimitW'(1);
    end else if (entries_ext > DepthLim) begin
      n_eff = DepthLim;
    end else begin
      n_eff = entries_ext;
    end
  end

  assign span   = hi_q - lo_q;
  assign lo_ext = ExtW'(lo_q);
  assign hi_ext = ExtW'(hi_q);

  shts_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  shts_cmp u_cmp (
    .a_high_i (key_high_q),
    .a_low_i  (key_low_q),
    .b_high_i (rd_data.key_high),
    .b_low_i  (rd_data.key_low),
    .res_o    (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    entries_d   = entries_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    piv_d       = piv_q;
    key_high_d  = key_high_q;
    key_low_d   = key_low_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_addr     = lo_q;

    // The output register empties as soon as the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i && cfg_ready_o) begin
      entries_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_data_i.req_type == shts_pkg::ReqLookup)) begin
          key_high_d = in_data_i.key_high;
          key_low_d  = in_data_i.key_low;
          lo_d       = '0;
          hi_d       = AddrW'(n_eff - shts_pkg::LimitW'(1));
          state_d    = S_STEP;
        end
      end
      S_STEP: begin
        // Halve while the range spans more than two entries, otherwise
        // fetch the range start for the first equality test.
        if (span > AddrW'(1)) begin
          piv_d   = lo_q + (span >> 1);
          rd_addr = lo_q + (span >> 1);
          state_d = S_CMP;
        end else begin
          rd_addr = lo_q;
          state_d = S_EQLO;
        end
      end
      S_CMP: begin
        if (cmp_res.gt) begin
          lo_d = piv_q + AddrW'(1);
        end else begin
          hi_d = piv_q;
        end
        state_d = S_STEP;
      end
      S_EQLO: begin
        if (cmp_res.eq) begin
          res_d   = '{found: 1'b1, match_index: lo_ext[shts_pkg::IdxW-1:0],
                      hit_count: rd_data.count};
          state_d = S_OUT;
        end else begin
          rd_addr = hi_q;
          state_d = S_EQHI;
        end
      end
      S_EQHI: begin
        if (cmp_res.eq) begin
          res_d = '{found: 1'b1, match_index: hi_ext[shts_pkg::IdxW-1:0],
                    hit_count: rd_data.count};
        end else begin
          res_d = '{found: 1'b0, match_index: '0, hit_count: '0};
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= shts_pkg::CfgW'(1);
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      piv_q       <= '0;
      key_high_q  <= '0;
      key_low_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      entries_q   <= entries_d;
      out_valid_q <= out_valid_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      piv_q       <= piv_d;
      key_high_q  <= key_high_d;
      key_low_q   <= key_low_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

endmodule

### hw/rtl/shts_table.sv
module shts_table #(
  parameter longint unsigned Depth = shts_pkg::TableDepthDefault,
  parameter int unsigned     AddrW = (Depth > 64'd1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  shts_pkg::entry_t     wr_data_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output shts_pkg::entry_t     rd_data_o
);

  shts_pkg::entry_t mem_q [0:Depth-1];
  shts_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data is registered; it follows the address in the next cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/shts_cmp.sv
module shts_cmp (
  input  logic [shts_pkg::HalfW-1:0] a_high_i,
  input  logic [shts_pkg::HalfW-1:0] a_low_i,
  input  logic [shts_pkg::HalfW-1:0] b_high_i,
  input  logic [shts_pkg::HalfW-1:0] b_low_i,
  output shts_pkg::cmp_res_t         res_o
);

  logic high_eq;

  // Unsigned 128-bit compare with the high word most significant.
  always_comb begin
    high_eq   = (a_high_i == b_high_i);
    res_o.eq  = high_eq && (a_low_i == b_low_i);
    res_o.gt  = high_eq ? (a_low_i > b_low_i) : (a_high_i > b_high_i);
  end

endmodule
